[design/pasm_pkg.sv]
package pasm_pkg;

   localparam int MAX_TERMS_DEF = 16;

   localparam int OPCODE_W = 2;
   localparam int DEGREE_W = 4;
   localparam int COEF_W   = 16;
   localparam int RDEG_W   = 5;
   localparam int RCOEF_W  = 40;
   localparam int PROD_W   = 2 * COEF_W;
   localparam int MODE_W   = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // opcodes of the request channel
   localparam logic [OPCODE_W-1:0] OP_SET_FIRST  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SET_SECOND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COMPUTE    = 2'd2;

   // operation_mode bits: bit 1 selects multiply, else bit 0 selects subtract
   localparam int MODE_SUB_BIT = 0;
   localparam int MODE_MUL_BIT = 1;

   // register word index carried in paddr[2]
   localparam logic CSR_IDX_MODE = 1'b0;

   typedef struct packed {
      logic wr_first;
      logic wr_second;
      logic clear_stores;
      logic issue;
      logic emit_mac;
      logic emit_addsub;
      logic sub;
      logic last;
   } pasm_cmd_type;

   typedef struct packed {
      logic out_free;
   } pasm_stat_type;

endpackage

[design/pasm_ctrl.sv]
module pasm_ctrl #(
   parameter int MAX_TERMS = pasm_pkg::MAX_TERMS_DEF,
   parameter int IDX_W     = $clog2(MAX_TERMS),
   parameter int OUT_W     = $clog2(2 * MAX_TERMS - 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pasm_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [pasm_pkg::MODE_W-1:0]   mode,
   input  pasm_pkg::pasm_stat_type       stat,
   output pasm_pkg::pasm_cmd_type        cmd,
   output logic [OUT_W-1:0]              out_idx,
   output logic [IDX_W-1:0]              term_idx
);
   import pasm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT_MUL,
      ST_EMIT_AS
   } state_type;

   localparam logic [OUT_W-1:0] TERMS_O    = OUT_W'(MAX_TERMS);
   localparam logic [OUT_W-1:0] TOP_TERM_O = OUT_W'(MAX_TERMS - 1);
   localparam logic [OUT_W-1:0] LAST_MUL   = OUT_W'(2 * MAX_TERMS - 2);

   state_type        state_ff;
   logic [OUT_W-1:0] i_ff;
   logic [IDX_W-1:0] j_ff;
   logic [IDX_W-1:0] jhi_ff;

   logic             accept;
   logic [OUT_W-1:0] i_nx;
   logic [OUT_W-1:0] jlo_nx;
   logic [OUT_W-1:0] jhi_nx;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_idx   = i_ff;
   assign term_idx  = j_ff;

   // term range of the next output: max(0, i-M+1) .. min(i, M-1)
   always_comb begin
      i_nx = i_ff + OUT_W'(1);
      if (i_nx < TERMS_O) begin
         jlo_nx = '0;
         jhi_nx = i_nx;
      end else begin
         jlo_nx = i_nx - TOP_TERM_O;
         jhi_nx = TOP_TERM_O;
      end
   end

   always_comb begin
      cmd             = '0;
      cmd.wr_first    = accept && (req_opcode == OP_SET_FIRST);
      cmd.wr_second   = accept && (req_opcode == OP_SET_SECOND);
      cmd.sub         = mode[MODE_SUB_BIT];
      unique case (state_ff)
         ST_MAC: begin
            cmd.issue = 1'b1;
         end
         ST_EMIT_MUL: begin
            cmd.emit_mac     = stat.out_free;
            cmd.last         = (i_ff == LAST_MUL);
            cmd.clear_stores = stat.out_free && (i_ff == LAST_MUL);
         end
         ST_EMIT_AS: begin
            cmd.emit_addsub  = stat.out_free;
            cmd.last         = (i_ff == TOP_TERM_O);
            cmd.clear_stores = stat.out_free && (i_ff == TOP_TERM_O);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         jhi_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_opcode == OP_COMPUTE)) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  jhi_ff   <= '0;
                  state_ff <= mode[MODE_MUL_BIT] ? ST_MAC : ST_EMIT_AS;
               end
            end
            ST_MAC: begin
               j_ff <= j_ff + IDX_W'(1);
               if (j_ff == jhi_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_EMIT_MUL;
            end
            ST_EMIT_MUL: begin
               if (stat.out_free) begin
                  if (i_ff == LAST_MUL) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     i_ff     <= i_nx;
                     j_ff     <= jlo_nx[IDX_W-1:0];
                     jhi_ff   <= jhi_nx[IDX_W-1:0];
                     state_ff <= ST_MAC;
                  end
               end
            end
            ST_EMIT_AS: begin
               if (stat.out_free) begin
                  i_ff <= i_nx;
                  if (i_ff == TOP_TERM_O) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[design/pasm_datapath.sv]
module pasm_datapath #(
   parameter int MAX_TERMS = pasm_pkg::MAX_TERMS_DEF,
   parameter int IDX_W     = $clog2(MAX_TERMS),
   parameter int OUT_W     = $clog2(2 * MAX_TERMS - 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pasm_pkg::pasm_cmd_type              cmd,
   output pasm_pkg::pasm_stat_type             stat,
   input  logic [OUT_W-1:0]                    out_idx,
   input  logic [IDX_W-1:0]                    term_idx,
   input  logic [pasm_pkg::DEGREE_W-1:0]       req_degree,
   input  logic signed [pasm_pkg::COEF_W-1:0]  req_coefficient,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pasm_pkg::RDEG_W-1:0]         rsp_result_degree,
   output logic signed [pasm_pkg::RCOEF_W-1:0] rsp_result_coefficient,
   output logic                                rsp_last
);
   import pasm_pkg::*;

   logic signed [COEF_W-1:0]  first_ff  [MAX_TERMS];
   logic signed [COEF_W-1:0]  second_ff [MAX_TERMS];
   logic [MAX_TERMS-1:0]      first_vld_ff;
   logic [MAX_TERMS-1:0]      second_vld_ff;

   logic signed [PROD_W-1:0]  prod_ff;
   logic                      prod_vld_ff;
   logic signed [RCOEF_W-1:0] acc_ff;

   logic                      rsp_valid_ff;
   logic [RDEG_W-1:0]         rsp_deg_ff;
   logic signed [RCOEF_W-1:0] rsp_coef_ff;
   logic                      rsp_last_ff;

   logic [31:0]               deg_ext;
   logic                      deg_ok;
   logic [IDX_W-1:0]          wr_idx;
   logic [OUT_W-1:0]          k_full;
   logic [IDX_W-1:0]          a_idx;
   logic [IDX_W-1:0]          b_idx;
   logic signed [COEF_W-1:0]  a_rd;
   logic signed [COEF_W-1:0]  b_rd;
   logic signed [RCOEF_W-1:0] a_ext;
   logic signed [RCOEF_W-1:0] b_ext;
   logic signed [RCOEF_W-1:0] as_val;
   logic [31:0]               rdeg_ext;

   assign deg_ext = 32'(req_degree);
   assign deg_ok  = (deg_ext < 32'(MAX_TERMS));
   assign wr_idx  = deg_ext[IDX_W-1:0];

   // multiply reads first[j] and second[i-j]; add/sub reads both at i
   assign k_full = out_idx - OUT_W'(term_idx);
   always_comb begin
      if (cmd.issue) begin
         a_idx = term_idx;
         b_idx = k_full[IDX_W-1:0];
      end else begin
         a_idx = out_idx[IDX_W-1:0];
         b_idx = out_idx[IDX_W-1:0];
      end
   end

   // entries never written since the last clear read as zero
   assign a_rd   = first_vld_ff[a_idx]  ? first_ff[a_idx]  : '0;
   assign b_rd   = second_vld_ff[b_idx] ? second_ff[b_idx] : '0;
   assign a_ext  = RCOEF_W'(a_rd);
   assign b_ext  = RCOEF_W'(b_rd);
   assign as_val = cmd.sub ? (a_ext - b_ext) : (a_ext + b_ext);

   assign rdeg_ext = 32'(out_idx);

   always_ff @(posedge clock) begin
      if (cmd.wr_first && deg_ok) begin
         first_ff[wr_idx] <= req_coefficient;
      end
      if (cmd.wr_second && deg_ok) begin
         second_ff[wr_idx] <= req_coefficient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_stores) begin
         first_vld_ff  <= '0;
         second_vld_ff <= '0;
      end else begin
         if (cmd.wr_first && deg_ok) begin
            first_vld_ff[wr_idx] <= 1'b1;
         end
         if (cmd.wr_second && deg_ok) begin
            second_vld_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         prod_ff <= a_rd * b_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= cmd.issue;
         if (cmd.emit_mac) begin
            acc_ff <= '0;
         end else if (prod_vld_ff) begin
            acc_ff <= acc_ff + RCOEF_W'(prod_ff);
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_mac || cmd.emit_addsub) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_mac || cmd.emit_addsub) begin
         rsp_deg_ff  <= rdeg_ext[RDEG_W-1:0];
         rsp_coef_ff <= cmd.emit_mac ? acc_ff : as_val;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_degree      = rsp_deg_ff;
   assign rsp_result_coefficient = rsp_coef_ff;
   assign rsp_last               = rsp_last_ff;

endmodule

[design/polynomial_add_sub_multiply_unit.sv]
// channel   direction  handshake             beat
// req       in         req_valid/req_stall   opcode, degree, coefficient
// rsp       out        rsp_valid/rsp_stall   result_degree, result_coefficient, last
// csr       in/out     psel/penable/pready   operation_mode at word 0
//
// Load items (and the unused opcode) leave the sequencer idle, so req stays open.
// Add/subtract emits MAX_TERMS beats at one per cycle while rsp is not stalled;
// multiply runs one shared 16x16 multiply-accumulate per term, and each output
// passes through the MAC, DRAIN and EMIT_MUL states in that order.
// Reset clears both coefficient stores and the mode register at once.
// A stalled rsp holds the sequencer; req is stalled for the whole compute.
module polynomial_add_sub_multiply_unit #(
   parameter int MAX_TERMS = pasm_pkg::MAX_TERMS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pasm_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [pasm_pkg::DEGREE_W-1:0]         req_degree,
   input  logic signed [pasm_pkg::COEF_W-1:0]    req_coefficient,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pasm_pkg::RDEG_W-1:0]           rsp_result_degree,
   output logic signed [pasm_pkg::RCOEF_W-1:0]   rsp_result_coefficient,
   output logic                                  rsp_last,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pasm_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [pasm_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [pasm_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import pasm_pkg::*;

   localparam int IDX_W = $clog2(MAX_TERMS);
   localparam int OUT_W = $clog2(2 * MAX_TERMS - 1);

   logic [MODE_W-1:0] mode_ff;
   logic              mode_sel;
   pasm_cmd_type      cmd;
   pasm_stat_type     stat;
   logic [OUT_W-1:0]  out_idx;
   logic [IDX_W-1:0]  term_idx;

   assign pready   = 1'b1;
   assign mode_sel = (paddr[2] == CSR_IDX_MODE);
   assign prdata   = mode_sel ? CSR_DATA_W'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else if (psel && penable && pwrite && pready && mode_sel) begin
         mode_ff <= pwdata[MODE_W-1:0];
      end
   end

   pasm_ctrl #(
      .MAX_TERMS (MAX_TERMS),
      .IDX_W     (IDX_W),
      .OUT_W     (OUT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .mode       (mode_ff),
      .stat       (stat),
      .cmd        (cmd),
      .out_idx    (out_idx),
      .term_idx   (term_idx)
   );

   pasm_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .IDX_W     (IDX_W),
      .OUT_W     (OUT_W)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .out_idx                (out_idx),
      .term_idx               (term_idx),
      .req_degree             (req_degree),
      .req_coefficient        (req_coefficient),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_degree      (rsp_result_degree),
      .rsp_result_coefficient (rsp_result_coefficient),
      .rsp_last               (rsp_last)
   );

`ifndef SYNTHESIS
   // MAC never runs while a new request could be taken
   assert property (@(posedge clock) disable iff (reset) cmd.issue |-> req_stall)
      else $error("multiply-accumulate active while req is open");

   // a beat is only loaded into a free output register
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_mac || cmd.emit_addsub) |-> stat.out_free)
      else $error("result loaded over an unaccepted beat");

   // stores are cleared only together with the final beat
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_stores |-> (cmd.last && (cmd.emit_mac || cmd.emit_addsub)))
      else $error("stores cleared outside the last beat");

   // after the last beat is loaded the sequencer is idle again
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_stores |=> !req_stall)
      else $error("sequencer not idle after last beat");
`endif

endmodule
